// ----- rtl/kmds_pkg.sv -----
// ----------------------------------------------------------------------------
// kmds_pkg
// Shared types, widths and the column drive table for the key matrix scanner.
// ----------------------------------------------------------------------------
package kmds_pkg;

  // fixed field widths
  localparam int unsigned MAX_ROWS = 8;
  localparam int unsigned MAX_COLS = 18;
  localparam int unsigned COL_W    = 5;
  localparam int unsigned PIN_W    = 8;
  localparam int unsigned ROWIDX_W = 3;
  localparam int unsigned DRIVE_W  = 6;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned DEB_W    = 8;

  localparam logic [DEB_W-1:0] DEB_RESET = 8'd5;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_SELECT = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_SCAN_END = 2'd2,
    FUNC_READ = 2'd3
  } kmds_func_t;

  typedef logic [MAX_COLS-1:0] kmds_row_t;
  typedef logic [CNT_W-1:0]    kmds_cnt_t;

  // control from the item stage to the matrix store
  typedef struct packed {
    logic                sample;
    logic                commit;
    logic [COL_W-1:0]    col;
    logic [PIN_W-1:0]    pins;
    logic [ROWIDX_W-1:0] row;
  } kmds_mat_ctrl_t;

  // status back from the matrix store
  typedef struct packed {
    logic      changed;
    kmds_row_t row_data;
    kmds_cnt_t key_count_nxt;
  } kmds_mat_sts_t;

  // demultiplexer drive bits (port bits 1 to 6) for each column
  function automatic logic [DRIVE_W-1:0] drive_code(input logic [COL_W-1:0] col);
    logic [DRIVE_W-1:0] code;
    case (col)
      5'd0:    code = 6'd29;
      5'd1:    code = 6'd44;
      5'd2:    code = 6'd56;
      5'd3:    code = 6'd55;
      5'd4:    code = 6'd54;
      5'd5:    code = 6'd53;
      5'd6:    code = 6'd52;
      5'd7:    code = 6'd50;
      5'd8:    code = 6'd48;
      5'd9:    code = 6'd49;
      5'd10:   code = 6'd13;
      5'd11:   code = 6'd12;
      5'd12:   code = 6'd30;
      5'd13:   code = 6'd51;
      5'd14:   code = 6'd28;
      5'd15:   code = 6'd57;
      5'd16:   code = 6'd15;
      5'd17:   code = 6'd31;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/kmds_if.sv -----
// ----------------------------------------------------------------------------
// kmds_if
// Valid/ready channels for scanner items and scanner results.
// ----------------------------------------------------------------------------
interface kmds_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [4:0] col;
  logic [7:0] row_pins;
  logic [2:0] row;

  modport source (output valid, func, col, row_pins, row, input ready);
  modport sink   (input valid, func, col, row_pins, row, output ready);
endinterface

interface kmds_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  col_drive;
  logic [17:0] row_bits;
  logic [7:0]  key_count;
  logic        settled;

  modport source (output valid, col_drive, row_bits, key_count, settled, input ready);
  modport sink   (input valid, col_drive, row_bits, key_count, settled, output ready);
endinterface

// ----- rtl/kmds_matrix.sv -----
// ----------------------------------------------------------------------------
// kmds_matrix
// Raw and stable key matrices with running pressed-key counts.
// ----------------------------------------------------------------------------
module kmds_matrix #(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kmds_pkg::kmds_mat_ctrl_t ctrl,
  output kmds_pkg::kmds_mat_sts_t  sts
);
  import kmds_pkg::*;

  logic [COLS-1:0] raw_r    [ROWS];
  logic [COLS-1:0] stable_r [ROWS];
  kmds_cnt_t       raw_count_r;
  kmds_cnt_t       raw_count_nxt;
  kmds_cnt_t       stable_count_r;

  logic [COLS-1:0] col_hot;
  logic            col_hit;
  logic [ROWS-1:0] new_col;
  logic [ROWS-1:0] old_col;
  kmds_cnt_t       pc_new;
  kmds_cnt_t       pc_old;
  logic            changed;
  logic [COLS-1:0] row_rd;

  // column decode and column compare
  always_comb begin
    col_hot = '0;
    for (int c = 0; c < COLS; c++) begin
      col_hot[c] = (ctrl.col == COL_W'(c));
    end
    col_hit = |col_hot;
    new_col = ~ctrl.pins[ROWS-1:0];
    pc_new  = '0;
    pc_old  = '0;
    for (int r = 0; r < ROWS; r++) begin
      old_col[r] = |(raw_r[r] & col_hot);
      pc_new     = pc_new + CNT_W'(new_col[r]);
      pc_old     = pc_old + CNT_W'(old_col[r]);
    end
    changed       = ctrl.sample && col_hit && (new_col != old_col);
    raw_count_nxt = changed ? (raw_count_r + pc_new - pc_old) : raw_count_r;
  end

  // stable row read
  always_comb begin
    row_rd = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (ctrl.row == ROWIDX_W'(r)) begin
        row_rd = stable_r[r];
      end
    end
  end

  assign sts.changed       = changed;
  assign sts.row_data      = kmds_row_t'(row_rd);
  assign sts.key_count_nxt = ctrl.commit ? raw_count_r : stable_count_r;

  // matrix and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) begin
        raw_r[r]    <= '0;
        stable_r[r] <= '0;
      end
      raw_count_r    <= '0;
      stable_count_r <= '0;
    end else begin
      if (changed) begin
        for (int r = 0; r < ROWS; r++) begin
          raw_r[r] <= (raw_r[r] & ~col_hot) | (new_col[r] ? col_hot : '0);
        end
      end
      if (ctrl.commit) begin
        for (int r = 0; r < ROWS; r++) begin
          stable_r[r] <= raw_r[r];
        end
        stable_count_r <= raw_count_r;
      end
      raw_count_r <= raw_count_nxt;
    end
  end

endmodule

// ----- rtl/key_matrix_debounce_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner_unit
// Key matrix scanner with debounce: column drive codes, raw sampling,
// quiet-scan countdown, commit to the stable matrix and row reads.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    func, col, row_pins, row
//   out_ch   out  valid/ready    col_drive, row_bits, key_count, settled
//   cfg      in   cfg_we         cfg_wdata (debounce_scans)
//
// One item per cycle sustained while out_ch.ready stays high; a result is
// offered once its item has passed the item register and then the result
// register.
// The result register sets the rate: a held result stalls the item register,
// which then drops in_ch.ready.
// Synchronous reset clears both matrices and loads the countdown and the
// debounce setting with 5; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_matrix_debounce_scanner_unit #(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 18
) (
  input  logic       clk,
  input  logic       rst_n,
  kmds_in_if.sink    in_ch,
  kmds_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import kmds_pkg::*;

  // item register
  logic                s1_valid_r;
  kmds_func_t          s1_func_r;
  logic [COL_W-1:0]    s1_col_r;
  logic [PIN_W-1:0]    s1_pins_r;
  logic [ROWIDX_W-1:0] s1_row_r;

  // result register
  logic               out_valid_r;
  logic [DRIVE_W-1:0] col_drive_r;
  kmds_row_t          row_bits_r;
  kmds_cnt_t          key_count_r;
  logic               settled_r;

  logic [DEB_W-1:0] debounce_r;
  logic [DEB_W-1:0] cd_r;
  logic [DEB_W-1:0] cd_nxt;

  logic out_free;
  logic adv;
  logic in_xfer;
  logic col_ok;
  logic [DRIVE_W-1:0] drive_nxt;

  kmds_mat_ctrl_t mat_ctrl;
  kmds_mat_sts_t  mat_sts;

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // item decode
  assign col_ok = (int'(s1_col_r) < COLS);

  assign mat_ctrl.sample = adv && (s1_func_r == FUNC_SAMPLE);
  assign mat_ctrl.commit = adv && (s1_func_r == FUNC_SCAN_END) && (cd_r == DEB_W'(1));
  assign mat_ctrl.col    = s1_col_r;
  assign mat_ctrl.pins   = s1_pins_r;
  assign mat_ctrl.row    = s1_row_r;

  kmds_matrix #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_matrix (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mat_ctrl),
    .sts   (mat_sts)
  );

  // quiet countdown
  always_comb begin
    cd_nxt = cd_r;
    if (mat_sts.changed) begin
      cd_nxt = debounce_r;
    end else if (adv && (s1_func_r == FUNC_SCAN_END) && (cd_r != '0)) begin
      cd_nxt = cd_r - DEB_W'(1);
    end
  end

  // drive code for select items
  assign drive_nxt = (s1_func_r == FUNC_SELECT && col_ok) ? drive_code(s1_col_r) : '0;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      debounce_r  <= DEB_RESET;
      cd_r        <= DEB_RESET;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        debounce_r <= (cfg_wdata == '0) ? DEB_W'(1) : cfg_wdata;
      end
      cd_r <= cd_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r <= kmds_func_t'(in_ch.func);
      s1_col_r  <= in_ch.col;
      s1_pins_r <= in_ch.row_pins;
      s1_row_r  <= in_ch.row;
    end
    if (adv) begin
      col_drive_r <= drive_nxt;
      row_bits_r  <= (s1_func_r == FUNC_READ) ? mat_sts.row_data : '0;
      key_count_r <= mat_sts.key_count_nxt;
      settled_r   <= (cd_nxt == '0);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.col_drive = col_drive_r;
  assign out_ch.row_bits  = row_bits_r;
  assign out_ch.key_count = key_count_r;
  assign out_ch.settled   = settled_r;

  // a raw change reloads the countdown from the setting
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    mat_sts.changed |=> cd_r == $past(debounce_r))
    else $error("countdown not reloaded after raw change");

  // a commit happens only on the scan end that brings the countdown to zero
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    mat_ctrl.commit |=> cd_r == '0)
    else $error("commit without countdown reaching zero");

  // an advancing item always lands in the result register
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result lost after item advance");

  // countdown never exceeds the debounce setting without a write
  a_cd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_we) && $past(cd_r) <= $past(debounce_r) |-> cd_r <= debounce_r)
    else $error("countdown above debounce setting");

endmodule

// ----- tb/sv/kmds_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmds_result_checker
// Watches the item and result channels of the key matrix scanner, keeps its
// own copy of the raw and stable matrices and the quiet countdown, predicts
// one result per item transfer and compares each result transfer, field by
// field, against the oldest prediction.
// ----------------------------------------------------------------------------
module kmds_result_checker (
  input  logic       clk,
  input  logic       rst_n,
  kmds_in_if         in_mon,
  kmds_out_if        out_mon,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         results_due,
  output int         fail_count
);
  import kmds_pkg::*;

  typedef struct packed {
    logic [5:0]  col_drive;
    logic [17:0] row_bits;
    logic [7:0]  key_count;
    logic        settled;
  } scan_result_t;

  // demultiplexer port codes per column, drive bits are port bits 1 to 6
  localparam logic [7:0] PORT_CODE [MAX_COLS] = '{
    8'h3A, 8'h58, 8'h70, 8'h6E, 8'h6C, 8'h6A, 8'h68, 8'h64, 8'h60,
    8'h62, 8'h1A, 8'h18, 8'h3C, 8'h66, 8'h38, 8'h72, 8'h1E, 8'h3E
  };

  logic [MAX_COLS-1:0] stable_rows [MAX_ROWS];
  logic [MAX_COLS-1:0] raw_rows [MAX_ROWS];
  logic [7:0]          quiet_left;
  logic [7:0]          debounce_set;
  scan_result_t        due_results [$];

  // apply one item to the matrix copy and build its result
  function automatic scan_result_t matrix_step(input kmds_func_t f, input logic [4:0] c,
                                               input logic [7:0] p, input logic [2:0] r);
    scan_result_t res;
    int           n;
    res = '0;
    case (f)
      FUNC_SELECT: begin
        if (c < MAX_COLS) res.col_drive = PORT_CODE[c][6:1];
      end
      FUNC_SAMPLE: begin
        // low pin level means pressed; any flip reloads the countdown
        if (c < MAX_COLS) begin
          for (int i = 0; i < MAX_ROWS; i++) begin
            if (p[i] == raw_rows[i][c]) begin
              raw_rows[i][c] = ~p[i];
              quiet_left = debounce_set;
            end
          end
        end
      end
      FUNC_SCAN_END: begin
        if (quiet_left != 8'd0) begin
          quiet_left = quiet_left - 8'd1;
          if (quiet_left == 8'd0) stable_rows = raw_rows;
        end
      end
      default: begin
        if (r < MAX_ROWS) res.row_bits = stable_rows[r];
      end
    endcase
    n = 0;
    for (int i = 0; i < MAX_ROWS; i++) n += $countones(stable_rows[i]);
    res.key_count = n[7:0];
    res.settled = (quiet_left == 8'd0);
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // track config writes and both channels at every edge
  always @(posedge clk) begin : track
    scan_result_t got;
    scan_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        stable_rows[i] = '0;
        raw_rows[i] = '0;
      end
      debounce_set = DEB_RESET;
      quiet_left = DEB_RESET;
      due_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) debounce_set = (cfg_wdata == 8'd0) ? 8'd1 : cfg_wdata;
      // result transfer
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.col_drive, out_mon.row_bits, out_mon.key_count, out_mon.settled};
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, actual %h", $time, got);
        end else begin
          want = due_results.pop_front();
          check_field("col_drive", want.col_drive, got.col_drive);
          check_field("row_bits", want.row_bits, got.row_bits);
          check_field("key_count", want.key_count, got.key_count);
          check_field("settled", want.settled, got.settled);
        end
      end
      // item transfer
      if (in_mon.valid && in_mon.ready)
        due_results.push_back(matrix_step(kmds_func_t'(in_mon.func), in_mon.col,
                                          in_mon.row_pins, in_mon.row));
    end
    results_due <= due_results.size();
  end

endmodule

// ----- tb/sv/key_matrix_debounce_scanner_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner_unit_tb
// Drives the key matrix scanner with a directed opening and then phases of
// random column scans, scan ends, row reads and noise items under several
// debounce settings and idle patterns, including a long receiver hold-off.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module key_matrix_debounce_scanner_unit_tb;
  import kmds_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         results_due;
  int         fail_count;
  int         send_idle;
  int         recv_stall;
  int         burst_req;
  int         burst_done;
  int         items_sent;
  int         quiet_cycles = 0;
  logic [7:0] key_pins [MAX_COLS];

  kmds_in_if  in_ch();
  kmds_out_if out_ch();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  key_matrix_debounce_scanner_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  kmds_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .results_due (results_due),
    .fail_count  (fail_count)
  );

  // offer one item after a random gap and wait for its transfer
  task automatic send_item(input kmds_func_t f, input logic [4:0] c,
                           input logic [7:0] p, input logic [2:0] r);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.col      <= c;
    in_ch.row_pins <= p;
    in_ch.row      <= r;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_scan_end();
    send_item(FUNC_SCAN_END, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
              3'($urandom_range(0, 7)));
  endtask

  // let every outstanding result drain, then a few more cycles
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [7:0] v);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly well-formed scans over a slowly bouncing keyboard, some noise
  task automatic run_traffic(input int n);
    int target;
    int pick;
    int c0;
    int c;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0)
        key_pins[$urandom_range(0, MAX_COLS-1)][$urandom_range(0, 7)] ^= 1'b1;
      if ($urandom_range(0, 39) == 0)
        key_pins[$urandom_range(0, MAX_COLS-1)] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if (pick < 55) begin
        c0 = $urandom_range(0, MAX_COLS-1);
        repeat ($urandom_range(1, MAX_COLS)) begin
          c = c0 % MAX_COLS;
          send_item(FUNC_SELECT, 5'(c), 8'($urandom_range(0, 255)),
                    3'($urandom_range(0, 7)));
          send_item(FUNC_SAMPLE, 5'(c), key_pins[c], 3'($urandom_range(0, 7)));
          c0++;
        end
        send_scan_end();
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 8)) send_scan_end();
      end else if (pick < 90) begin
        send_item(FUNC_READ, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                  3'($urandom_range(0, 7)));
      end else begin
        send_item(kmds_func_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  // result side: random stalls plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    burst_done = 0;
    forever begin
      @(posedge clk);
      if (burst_done != burst_req) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        burst_done++;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_SELECT;
    in_ch.col      = '0;
    in_ch.row_pins = '0;
    in_ch.row      = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    send_idle      = 0;
    recv_stall     = 0;
    burst_req      = 0;
    items_sent     = 0;
    foreach (key_pins[i]) key_pins[i] = 8'hFF;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: drive codes at the column extremes and out of range
    send_item(FUNC_SELECT, 5'd0, 8'h00, 3'd0);
    send_item(FUNC_SELECT, 5'd17, 8'hFF, 3'd7);
    send_item(FUNC_SELECT, 5'd18, 8'h00, 3'd0);
    send_item(FUNC_SELECT, 5'd31, 8'hFF, 3'd7);
    // samples, out-of-range columns ignored
    send_item(FUNC_SAMPLE, 5'd0, 8'h00, 3'd0);
    send_item(FUNC_SAMPLE, 5'd17, 8'hFE, 3'd0);
    send_item(FUNC_SAMPLE, 5'd18, 8'h00, 3'd0);
    send_item(FUNC_SAMPLE, 5'd31, 8'h00, 3'd0);
    send_item(FUNC_READ, 5'd0, 8'h00, 3'd0);
    // quiet scans up to the commit, then one more while settled
    repeat (6) send_item(FUNC_SCAN_END, 5'd0, 8'h00, 3'd0);
    send_item(FUNC_READ, 5'd31, 8'hFF, 3'd0);
    send_item(FUNC_READ, 5'd0, 8'h00, 3'd7);
    // release a column and press a pattern, no commit yet
    send_item(FUNC_SAMPLE, 5'd0, 8'hFF, 3'd0);
    send_item(FUNC_SAMPLE, 5'd9, 8'h55, 3'd0);
    send_item(FUNC_READ, 5'd0, 8'h00, 3'd1);

    // shortest debounce, no idling
    write_debounce(8'd1);
    run_traffic(130);

    // zero setting behaves as one, sender mostly idle
    write_debounce(8'd0);
    send_idle = 76;
    run_traffic(110);

    // receiver mostly stalling, with one long hold-off while items keep coming
    write_debounce(8'd3);
    send_idle = 0;
    recv_stall = 76;
    burst_req++;
    run_traffic(110);

    // longest debounce, both sides idling, then a long quiet run to commit
    write_debounce(8'd255);
    send_idle = 28;
    recv_stall = 28;
    run_traffic(80);
    repeat (258) send_scan_end();
    for (int i = 0; i < MAX_ROWS; i++)
      send_item(FUNC_READ, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)), 3'(i));

    // random middle setting, no idling
    write_debounce(8'($urandom_range(2, 20)));
    send_idle = 0;
    recv_stall = 0;
    run_traffic(80);

    settle_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
